FILE: hw/rtl/olfbr_pkg.sv
// Shared constants for the ordered list block: default depth, data width,
// request opcodes and result status codes. No dependencies.
package olfbr_pkg;

  // Default number of list entries and width of one stored value.
  localparam int OLFBR_DEPTH = 16;
  localparam int DATA_W      = 32;

  // Request opcodes.
  localparam logic [1:0] OP_INS_FRONT = 2'd0;
  localparam logic [1:0] OP_INS_BACK  = 2'd1;
  localparam logic [1:0] OP_REMOVE    = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

endpackage

FILE: hw/rtl/olfbr_ifs.sv
// Valid/ready channel interfaces for the ordered list block: one for
// requests and one for results. Depends on olfbr_pkg.

// Request channel: opcode and value.
interface olfbr_in_if import olfbr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Result channel: status, count, empty flag and the two end values.
interface olfbr_out_if import olfbr_pkg::*; #(
  parameter int CNT_W = $clog2(OLFBR_DEPTH + 1)
) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic                     empty_flag;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output status, output count, output empty_flag,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input count, input empty_flag,
                  input front_value, input back_value, output ready);
endinterface

FILE: hw/rtl/ordered_list_front_back_remove_top.sv
// Ordered list of signed values kept in a ring memory of DEPTH entries.
// Depends on olfbr_pkg and the channel interfaces in olfbr_ifs.sv.
//
// Usage: each request on in_ch carries an opcode (insert at front, insert
// at back, remove the first equal entry, clear) and a value. Exactly one
// result per request leaves on out_ch with the status, the entry count,
// an empty flag and the front and back values after the operation.
// Requests are handled one at a time; in_ch.ready is high while the block
// waits for a request, also while an earlier result sits in the output register.
// Steps: the request is executed; a remove first searches the list from the
// front and then closes the gap behind the match; then the front and back
// values are read back unless the list is empty, and the result is loaded.
// All reads go through the single registered read port of the ring memory,
// and a new request is taken only once the last result has been loaded.
// Reset empties the list (count and head return to zero); the memory
// itself is not cleared. If out_ch stalls, the finished result waits in
// the output register and the next result waits in its final state.
module ordered_list_front_back_remove_top import olfbr_pkg::*; #(
  parameter int DEPTH = OLFBR_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  olfbr_in_if.sink   in_ch,
  olfbr_out_if.source out_ch
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SEARCH, S_SHIFT, S_FRONT, S_BACK, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [CNT_W-1:0]         pend_off_r, pend_off_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [DATA_W-1:0]        front_r, front_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [DATA_W-1:0]        out_front_r, out_front_nxt;
  logic [DATA_W-1:0]        out_back_r, out_back_nxt;

  // Ring memory with one write port and one registered read port.
  logic [DATA_W-1:0]        mem [DEPTH];
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_data_r;

  logic [IDX_W-1:0]         head_dec;
  logic                     is_full;

  // Ring slot of the entry at a given distance from the front.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);
  assign is_full  = (count_r == CNT_W'(DEPTH));

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.empty_flag  = out_empty_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;

  // Sequencer: execute the request, then read back the two end values.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_off_nxt   = pend_off_r;
    status_nxt     = status_r;
    front_nxt      = front_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_front_nxt  = out_front_r;
    out_back_nxt   = out_back_r;
    mem_we         = 1'b0;
    mem_waddr      = slot(head_r, pend_off_r);
    mem_wdata      = rd_data_r;
    rd_en          = 1'b0;
    rd_addr        = slot(head_r, idx_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          val_nxt   = in_ch.value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_DONE;
        state_nxt  = S_FRONT;
        unique case (op_r)
          OP_INS_FRONT: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              head_nxt  = head_dec;
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              mem_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_INS_BACK: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot(head_r, count_r);
              mem_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SEARCH;
          end
          default: begin
            count_nxt = '0;
            head_nxt  = '0;
          end
        endcase
      end

      // Read one entry a cycle and compare the one read the cycle before.
      S_SEARCH: begin
        if (pend_r && (rd_data_r == val_r)) begin
          idx_nxt   = pend_off_r + CNT_W'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else if (idx_r < count_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_off_nxt = idx_r;
          idx_nxt      = idx_r + CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FRONT;
        end
      end

      // Close the gap: each entry behind the match moves one slot forward.
      S_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (idx_r < count_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_off_nxt = idx_r - CNT_W'(1);
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CNT_W'(1);
            if (count_r == CNT_W'(1)) begin
              head_nxt = '0;
            end
            state_nxt = S_FRONT;
          end
        end
      end

      S_FRONT: begin
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = slot(head_r, '0);
          state_nxt = S_BACK;
        end
      end

      S_BACK: begin
        front_nxt = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = slot(head_r, count_r - CNT_W'(1));
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_r;
          out_empty_nxt  = (count_r == '0);
          out_front_nxt  = (count_r == '0) ? '0 : front_r;
          out_back_nxt   = (count_r == '0) ? '0 : rd_data_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    pend_off_r   <= pend_off_nxt;
    status_r     <= status_nxt;
    front_r      <= front_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_front_r  <= out_front_nxt;
    out_back_r   <= out_back_nxt;
  end

  // Ring memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: dv/olfbr_list_monitor.sv
// Result checker for the ordered list block: watches both channels, predicts
// each result from its own copy of the list and compares field by field.
// Depends on olfbr_pkg and the channel interfaces in olfbr_ifs.sv.
`timescale 1ns / 1ps

module olfbr_list_monitor import olfbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  olfbr_in_if  in_ch,
  olfbr_out_if out_ch,
  output int   n_errors,
  output int   n_pending,
  output int   n_checked,
  output int   n_full_hits,
  output int   n_miss_hits
);

  localparam int LIST_DEPTH = OLFBR_DEPTH;

  // One predicted result, at the widths of the result channel.
  typedef struct packed {
    logic [1:0]               status;
    logic [4:0]               count;
    logic                     empty_flag;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } list_result_t;

  // Shadow copy of the ring: slots, front position and fill level.
  logic signed [DATA_W-1:0] ring [LIST_DEPTH];
  int                       ring_head = 0;
  int                       ring_fill = 0;

  list_result_t expected_results[$];
  list_result_t want;
  int           errs = 0;
  int           checked = 0;
  int           full_hits = 0;
  int           miss_hits = 0;

  assign n_errors    = errs;
  assign n_checked   = checked;
  assign n_full_hits = full_hits;
  assign n_miss_hits = miss_hits;

  function automatic int ring_slot(int offset);
    return (ring_head + offset) % LIST_DEPTH;
  endfunction

  // Applies one request to the shadow list and returns the result it causes.
  function automatic list_result_t apply_request(logic [1:0] op,
                                                 logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           hit;
    r.status = ST_DONE;
    hit = -1;
    case (op)
      OP_INS_FRONT: begin
        if (ring_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_head = (ring_head + LIST_DEPTH - 1) % LIST_DEPTH;
          ring[ring_head] = val;
          ring_fill++;
        end
      end
      OP_INS_BACK: begin
        if (ring_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[ring_slot(ring_fill)] = val;
          ring_fill++;
        end
      end
      OP_REMOVE: begin
        // The first match from the front wins; entries behind it close the gap.
        for (int k = 0; k < ring_fill; k++) begin
          if (hit < 0 && ring[ring_slot(k)] == val) hit = k;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = hit; k + 1 < ring_fill; k++) begin
            ring[ring_slot(k)] = ring[ring_slot(k + 1)];
          end
          ring_fill--;
          if (ring_fill == 0) ring_head = 0;
        end
      end
      default: begin
        ring_fill = 0;
        ring_head = 0;
      end
    endcase
    r.count      = 5'(ring_fill);
    r.empty_flag = (ring_fill == 0);
    if (ring_fill == 0) begin
      r.front_value = '0;
      r.back_value  = '0;
    end else begin
      r.front_value = ring[ring_slot(0)];
      r.back_value  = ring[ring_slot(ring_fill - 1)];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH on result %0d: %s", $realtime, checked, msg);
    errs++;
  endtask

  // Results are compared before new requests are queued, so a result and a
  // request that meet at the same edge are matched in the right order.
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_head = 0;
      ring_fill = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no request waiting");
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_FULL) full_hits++;
          if (want.status == ST_NOT_FOUND) miss_hits++;
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_ch.count, want.count));
          if (out_ch.empty_flag !== want.empty_flag)
            report_mismatch($sformatf("empty_flag %b, expected %b",
                                      out_ch.empty_flag, want.empty_flag));
          if (out_ch.front_value !== want.front_value)
            report_mismatch($sformatf("front_value %0d, expected %0d",
                                      out_ch.front_value, want.front_value));
          if (out_ch.back_value !== want.back_value)
            report_mismatch($sformatf("back_value %0d, expected %0d",
                                      out_ch.back_value, want.back_value));
        end
        checked++;
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(apply_request(in_ch.opcode, in_ch.value));
    end
    n_pending <= expected_results.size();
  end

endmodule

FILE: dv/tb_top.sv
// Top of the ordered list testbench: clock, reset, request and result
// handshakes with random idling. Depends on olfbr_pkg, olfbr_ifs.sv,
// the block itself and olfbr_list_monitor.
`timescale 1ns / 1ps

module tb_top;
  import olfbr_pkg::*;

  localparam int N_REQUESTS   = 850;
  localparam int TAIL_ITEMS   = 120;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  olfbr_in_if  in_ch ();
  olfbr_out_if out_ch ();

  int n_errors, n_pending, n_checked, n_full_hits, n_miss_hits;

  int sent = 0;
  int cycles = 0;
  int send_idle_pct = 20;
  int insert_pct = 50;
  bit quiet = 1'b0;
  bit holding = 1'b0;
  bit hold_done = 1'b0;
  logic signed [DATA_W-1:0] hot_values [8];

  ordered_list_front_back_remove_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  olfbr_list_monitor u_list_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_checked   (n_checked),
    .n_full_hits (n_full_hits),
    .n_miss_hits (n_miss_hits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ordered_list_front_back_remove_top test failed");
      $finish;
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send_request(logic [1:0] op, logic signed [DATA_W-1:0] val);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Random idle burst on the request side, skipped while results are held and during the closing stretch.
  task automatic sender_gap();
    if (!quiet && !holding && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  // Stops offering until every predicted result has been claimed.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // Values are drawn mostly from a small pool so that removes find matches
  // and duplicates occur; the rest are fully random.
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 65) return hot_values[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_opcode();
    int r;
    r = $urandom_range(99);
    if (r < 3) return OP_CLEAR;
    if (r < 3 + insert_pct) return $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
    return OP_REMOVE;
  endfunction

  // Result side: random stalls, one long hold-off to back the block up,
  // and none at all during the closing stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (!hold_done && sent >= HOLD_AT) begin
        holding = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(99) < 15) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Request side and verdict.
  initial begin
    int chunk;
    int chunk_len;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_CLEAR;
    in_ch.value  <= '0;
    hot_values[0] = 32'sh8000_0000;
    hot_values[1] = 32'sh7fff_ffff;
    hot_values[2] = '0;
    hot_values[3] = -1;
    for (int k = 4; k < 8; k++) hot_values[k] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clear and remove on an empty list.
    send_request(OP_CLEAR, 32'sd5);
    send_request(OP_REMOVE, 32'sd5);
    // Extremes at both ends, giving the list 0, min, max, -1.
    send_request(OP_INS_FRONT, 32'sh8000_0000);
    send_request(OP_INS_BACK, 32'sh7fff_ffff);
    send_request(OP_INS_FRONT, 32'sd0);
    send_request(OP_INS_BACK, -32'sd1);
    // Middle entry, a miss, the front, the back, then the only entry.
    send_request(OP_REMOVE, 32'sh7fff_ffff);
    send_request(OP_REMOVE, 32'sd7);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_REMOVE, -32'sd1);
    send_request(OP_REMOVE, 32'sh8000_0000);
    // Fill from both ends, then both inserts against a full list.
    for (int k = 0; k < OLFBR_DEPTH; k++) begin
      send_request((k % 2) ? OP_INS_BACK : OP_INS_FRONT, $urandom);
    end
    send_request(OP_INS_FRONT, 32'sd1);
    send_request(OP_INS_BACK, 32'sd2);
    send_request(OP_CLEAR, '0);
    drain_results();

    // Random phases, each leaning toward filling, draining or balance.
    chunk = 0;
    while (sent < N_REQUESTS - TAIL_ITEMS) begin
      case ($urandom_range(2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 25;
      endcase
      send_idle_pct = $urandom_range(1) ? 25 : 0;
      chunk_len = $urandom_range(60, 20);
      for (int k = 0; k < chunk_len; k++) begin
        send_request(pick_opcode(), pick_value());
        sender_gap();
      end
      chunk++;
      if (chunk == 5) drain_results();
    end

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    insert_pct = 50;
    while (sent < N_REQUESTS) send_request(pick_opcode(), pick_value());
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (n_pending != 0);
    repeat (64) @(posedge clk);

    $display("Sent %0d requests and checked %0d results across fill, drain and clear phases.",
             sent, n_checked);
    $display("%0d inserts met a full list, %0d removes found no match; %0d mismatches.",
             n_full_hits, n_miss_hits, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("ordered_list_front_back_remove_top test passed");
    end else begin
      $display("ordered_list_front_back_remove_top test failed");
    end
    $finish;
  end

endmodule
